@@ design/forp_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// forp_pkg
// Shared types, widths and exp factor constants of the fuzzy order pair unit.
// ----------------------------------------------------------------------------
package forp_pkg;

  localparam int SampleW   = 24;
  localparam int FracBits  = 16;
  localparam int DegW      = FracBits + 1;
  localparam int QuoW      = 29;
  localparam int ExpStages = 29;
  localparam int FifoDepth = 4;
  localparam int PtrW      = 2;
  localparam int CntW      = 3;

  localparam logic [DegW-1:0] OneDeg = DegW'(1) << FracBits;

  typedef enum logic [2:0] {
    MODE_CLASSIC = 3'd0,
    MODE_LINEAR  = 3'd1,
    MODE_EXP     = 3'd2,
    MODE_GAUSS   = 3'd3,
    MODE_EPS     = 3'd4
  } mode_e;

  typedef enum logic [1:0] {
    REG_MODE    = 2'd0,
    REG_SCALE_X = 2'd1,
    REG_SCALE_Y = 2'd2
  } reg_idx_e;

  typedef enum logic [1:0] {
    KIND_FIXED = 2'd0,
    KIND_LIN   = 2'd1,
    KIND_EXP   = 2'd2,
    KIND_GAU   = 2'd3
  } kind_e;

  typedef struct packed {
    kind_e               kind;
    logic                fw_one;
    logic                bw_one;
    logic                dir_fw;
    logic [SampleW-1:0]  d;
    logic [SampleW-1:0]  r;
  } lane_side_t;

  typedef struct packed {
    lane_side_t x;
    lane_side_t y;
  } item_t;

  function automatic logic [63:0] udiv64(logic [63:0] n, logic [63:0] dv);
    logic [63:0] q;
    logic [63:0] rm;
    q  = '0;
    rm = '0;
    for (int i = 63; i >= 0; i--) begin
      rm = {rm[62:0], n[i]};
      if (rm >= dv) begin
        rm   = rm - dv;
        q[i] = 1'b1;
      end
    end
    return q;
  endfunction

  function automatic logic [31:0] series_factor(int s);
    logic [63:0] sum;
    logic [63:0] term;
    logic [63:0] rnd;
    logic        done;
    sum  = 64'd1 << 60;
    term = 64'd1 << 60;
    done = 1'b0;
    for (int n = 1; n < 64; n++) begin
      if (!done) begin
        term = udiv64(term >> s, 64'(n));
        if (term == 64'd0) begin
          done = 1'b1;
        end else if (n % 2 == 1) begin
          sum = sum - term;
        end else begin
          sum = sum + term;
        end
      end
    end
    rnd = (sum + (64'd1 << 28)) >> 29;
    return rnd[31:0];
  endfunction

  function automatic logic [31:0] exp_factor(int k);
    logic [63:0] c;
    if (k < 24) begin
      return series_factor(24 - k);
    end
    c = {32'd0, series_factor(1)};
    for (int i = 24; i <= k; i++) begin
      c = (c * c + (64'd1 << 30)) >> 31;
    end
    return c[31:0];
  endfunction

endpackage

@@ design/forp_front.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// forp_front
// Accepts sample pairs, classifies each variable and holds one item for the
// queue.
// ----------------------------------------------------------------------------
module forp_front (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic [2:0]                    mode_i,
  input  logic [forp_pkg::SampleW-1:0]  scale_x_i,
  input  logic [forp_pkg::SampleW-1:0]  scale_y_i,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic signed [forp_pkg::SampleW-1:0] x_first_i,
  input  logic signed [forp_pkg::SampleW-1:0] x_second_i,
  input  logic signed [forp_pkg::SampleW-1:0] y_first_i,
  input  logic signed [forp_pkg::SampleW-1:0] y_second_i,
  output logic                          push_o,
  output forp_pkg::item_t               item_o,
  input  logic                          full_i
);

  function automatic forp_pkg::lane_side_t classify(
    logic [2:0] m, logic signed [forp_pkg::SampleW-1:0] a,
    logic signed [forp_pkg::SampleW-1:0] b, logic [forp_pkg::SampleW-1:0] r);
    forp_pkg::lane_side_t s;
    logic signed [forp_pkg::SampleW+1:0] dba;
    logic signed [forp_pkg::SampleW+1:0] dab;
    logic signed [forp_pkg::SampleW+1:0] rs;
    logic [forp_pkg::SampleW+4:0]        r32;
    dba = (forp_pkg::SampleW+2)'(b) - (forp_pkg::SampleW+2)'(a);
    dab = (forp_pkg::SampleW+2)'(a) - (forp_pkg::SampleW+2)'(b);
    rs  = $signed({2'b00, r});
    s.kind   = forp_pkg::KIND_FIXED;
    s.fw_one = 1'b0;
    s.bw_one = 1'b0;
    s.dir_fw = (a < b);
    s.d      = (a < b) ? dba[forp_pkg::SampleW-1:0] : dab[forp_pkg::SampleW-1:0];
    s.r      = r;
    r32      = {5'b00000, r};
    unique case (m)
      forp_pkg::MODE_EPS: begin
        s.fw_one = (dba > rs);
        s.bw_one = (dab > rs);
      end
      forp_pkg::MODE_LINEAR, forp_pkg::MODE_EXP, forp_pkg::MODE_GAUSS: begin
        if (s.d == '0) begin
          s.kind = forp_pkg::KIND_FIXED;
        end else if (r == '0
                     || (m == forp_pkg::MODE_LINEAR && s.d >= r)
                     || (m == forp_pkg::MODE_EXP && {5'b00000, s.d} >= (r32 << 5))
                     || (m == forp_pkg::MODE_GAUSS && {5'b00000, s.d} >= (r32 << 3))) begin
          s.fw_one = s.dir_fw;
          s.bw_one = ~s.dir_fw;
        end else if (m == forp_pkg::MODE_LINEAR) begin
          s.kind = forp_pkg::KIND_LIN;
        end else if (m == forp_pkg::MODE_EXP) begin
          s.kind = forp_pkg::KIND_EXP;
        end else begin
          s.kind = forp_pkg::KIND_GAU;
        end
      end
      default: begin
        s.fw_one = (a < b);
        s.bw_one = (a > b);
      end
    endcase
    return s;
  endfunction

  logic            fv_q;
  forp_pkg::item_t item_q;

  assign push_o     = fv_q & ~full_i;
  assign in_ready_o = ~fv_q | push_o;
  assign item_o     = item_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fv_q <= 1'b0;
    end else if (in_ready_o) begin
      fv_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      item_q.x <= classify(mode_i, x_first_i, x_second_i, scale_x_i);
      item_q.y <= classify(mode_i, y_first_i, y_second_i, scale_y_i);
    end
  end

endmodule

@@ design/forp_fifo.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// forp_fifo
// Short queue of classified items between the front and the back.
// ----------------------------------------------------------------------------
module forp_fifo (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            push_i,
  input  forp_pkg::item_t item_i,
  output logic            full_o,
  input  logic            pop_i,
  output logic            empty_o,
  output forp_pkg::item_t item_o
);

  forp_pkg::item_t               mem_q [forp_pkg::FifoDepth];
  logic [forp_pkg::PtrW-1:0]     wr_q;
  logic [forp_pkg::PtrW-1:0]     rd_q;
  logic [forp_pkg::CntW-1:0]     cnt_q;

  assign full_o  = (cnt_q == forp_pkg::CntW'(forp_pkg::FifoDepth));
  assign empty_o = (cnt_q == '0);
  assign item_o  = mem_q[rd_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (push_i) begin
        wr_q <= wr_q + 1'b1;
      end
      if (pop_i) begin
        rd_q <= rd_q + 1'b1;
      end
      cnt_q <= cnt_q + forp_pkg::CntW'(push_i) - forp_pkg::CntW'(pop_i);
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_q] <= item_i;
    end
  end

  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_i |-> !full_o) else $error("push into full queue");
  a_no_underflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_i |-> !empty_o) else $error("pop from empty queue");
  a_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (push_i && !pop_i) |=> cnt_q == $past(cnt_q) + 1'b1) else $error("count slip");

endmodule

@@ design/forp_lane.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// forp_lane
// One variable's datapath: bit-per-stage divider, square, exp factor chain.
// ----------------------------------------------------------------------------
module forp_lane (
  input  logic                        clk_i,
  input  logic                        en_i,
  input  forp_pkg::lane_side_t        side_i,
  output logic [forp_pkg::DegW-1:0]   fw_o,
  output logic [forp_pkg::DegW-1:0]   bw_o
);

  localparam int QW = forp_pkg::QuoW;
  localparam int SW = forp_pkg::SampleW;
  localparam int EN = forp_pkg::ExpStages;

  logic [SW:0]             rem_q [QW];
  logic [QW-1:0]           quo_q [QW];
  forp_pkg::lane_side_t    sd_q  [QW];

  for (genvar k = 0; k < QW; k++) begin : g_div
    localparam int B = QW - 1 - k;
    logic [SW-1:0]        rin;
    logic [QW-1:0]        qin;
    forp_pkg::lane_side_t sin;
    logic                 nbit;
    logic [SW:0]          sh;
    logic                 ge;
    if (k == 0) begin : g_first
      assign rin = {5'b0, side_i.d[SW-1:5]};
      assign qin = '0;
      assign sin = side_i;
    end else begin : g_rest
      assign rin = rem_q[k-1][SW-1:0];
      assign qin = quo_q[k-1];
      assign sin = sd_q[k-1];
    end
    if (B >= SW) begin : g_dbit
      assign nbit = sin.d[B-SW];
    end else begin : g_zbit
      assign nbit = 1'b0;
    end
    assign sh = {rin, nbit};
    assign ge = (sh >= {1'b0, sin.r});
    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rem_q[k]    <= ge ? sh - {1'b0, sin.r} : sh;
        quo_q[k]    <= qin | (QW'(ge) << B);
        sd_q[k]     <= sin;
      end
    end
  end

  logic [53:0]          sq_prod;
  logic [QW-1:0]        t_q;
  forp_pkg::lane_side_t st_q;

  assign sq_prod = {27'd0, quo_q[QW-1][26:0]} * {27'd0, quo_q[QW-1][26:0]};

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      t_q  <= (sd_q[QW-1].kind == forp_pkg::KIND_GAU) ? sq_prod[53:25] : quo_q[QW-1];
      st_q <= sd_q[QW-1];
    end
  end

  logic [31:0]          e_q  [EN];
  logic [QW-1:0]        te_q [EN];
  forp_pkg::lane_side_t se_q [EN];

  for (genvar j = 0; j < EN; j++) begin : g_exp
    localparam logic [31:0] CJ = forp_pkg::exp_factor(j);
    logic [31:0]          ein;
    logic [QW-1:0]        tin;
    forp_pkg::lane_side_t sin;
    logic [63:0]          prod;
    logic [63:0]          rnd;
    if (j == 0) begin : g_first
      assign ein = 32'h8000_0000;
      assign tin = t_q;
      assign sin = st_q;
    end else begin : g_rest
      assign ein = e_q[j-1];
      assign tin = te_q[j-1];
      assign sin = se_q[j-1];
    end
    assign prod = {32'd0, ein} * {32'd0, CJ};
    assign rnd  = prod + (64'd1 << 30);
    always_ff @(posedge clk_i) begin
      if (en_i) begin
        e_q[j]  <= tin[j] ? rnd[62:31] : ein;
        te_q[j] <= tin;
        se_q[j] <= sin;
      end
    end
  end

  forp_pkg::lane_side_t   sf;
  logic [32:0]            es;
  logic [17:0]            qq;
  logic [forp_pkg::DegW-1:0] v;

  assign sf = se_q[EN-1];
  assign es = {1'b0, e_q[EN-1]} + 33'd16384;
  assign qq = es[32:15];

  always_comb begin
    if (sf.kind == forp_pkg::KIND_LIN) begin
      v = {1'b0, te_q[EN-1][23:8]};
    end else if (qq > {1'b0, forp_pkg::OneDeg}) begin
      v = '0;
    end else begin
      v = forp_pkg::OneDeg - qq[forp_pkg::DegW-1:0];
    end
    if (sf.kind == forp_pkg::KIND_FIXED) begin
      fw_o = sf.fw_one ? forp_pkg::OneDeg : '0;
      bw_o = sf.bw_one ? forp_pkg::OneDeg : '0;
    end else begin
      fw_o = sf.dir_fw ? v : '0;
      bw_o = sf.dir_fw ? '0 : v;
    end
  end

endmodule

@@ design/forp_back.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// forp_back
// Stalling pipeline over both lanes with the output register.
// ----------------------------------------------------------------------------
module forp_back (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      empty_i,
  input  forp_pkg::item_t           item_i,
  output logic                      pop_o,
  output logic                      out_valid_o,
  input  logic                      out_ready_i,
  output logic [forp_pkg::DegW-1:0] x_fw_o,
  output logic [forp_pkg::DegW-1:0] x_bw_o,
  output logic [forp_pkg::DegW-1:0] y_fw_o,
  output logic [forp_pkg::DegW-1:0] y_bw_o
);

  localparam int NS = forp_pkg::QuoW + 1 + forp_pkg::ExpStages;

  logic                      en;
  logic [NS-1:0]             vld_q;
  logic                      ov_q;
  logic [forp_pkg::DegW-1:0] xf, xb, yf, yb;

  assign en          = ~ov_q | out_ready_i;
  assign pop_o       = en & ~empty_i;
  assign out_valid_o = ov_q;

  forp_lane u_lane_x (.clk_i, .en_i(en), .side_i(item_i.x), .fw_o(xf), .bw_o(xb));
  forp_lane u_lane_y (.clk_i, .en_i(en), .side_i(item_i.y), .fw_o(yf), .bw_o(yb));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
      ov_q  <= 1'b0;
    end else if (en) begin
      vld_q <= {vld_q[NS-2:0], ~empty_i};
      ov_q  <= vld_q[NS-1];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      x_fw_o <= xf;
      x_bw_o <= xb;
      y_fw_o <= yf;
      y_bw_o <= yb;
    end
  end

  a_stall_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !en |=> $stable(vld_q)) else $error("pipeline moved during stall");
  a_pop_en: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_o |=> vld_q[0]) else $error("popped item lost");
  a_out_from_pipe: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(ov_q) |-> $past(vld_q[NS-1])) else $error("result without item");

endmodule

@@ design/fuzzy_order_relation_pair_unit.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fuzzy_order_relation_pair_unit
// Fuzzy order degrees for one pair of samples of two variables, APB config.
// ----------------------------------------------------------------------------
// pipeline from input transfer to result valid: front register, 1 queue write,
// 29 divider stages, 1 square, 29 exp stages, 1 out
// throughput: one item per cycle (pipelined lanes) unless the output stalls
// reset: config regs to mode 0, scales 1; queue and pipeline emptied at once
module fuzzy_order_relation_pair_unit (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic signed [forp_pkg::SampleW-1:0] x_first_i,
  input  logic signed [forp_pkg::SampleW-1:0] x_second_i,
  input  logic signed [forp_pkg::SampleW-1:0] y_first_i,
  input  logic signed [forp_pkg::SampleW-1:0] y_second_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [forp_pkg::DegW-1:0] x_forward_degree_o,
  output logic [forp_pkg::DegW-1:0] x_backward_degree_o,
  output logic [forp_pkg::DegW-1:0] y_forward_degree_o,
  output logic [forp_pkg::DegW-1:0] y_backward_degree_o
);

  logic [2:0]                   mode_q;
  logic [forp_pkg::SampleW-1:0] scale_x_q;
  logic [forp_pkg::SampleW-1:0] scale_y_q;
  logic                         wr;

  assign pready = 1'b1;
  assign wr     = psel & penable & pwrite & pready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q    <= forp_pkg::MODE_CLASSIC;
      scale_x_q <= forp_pkg::SampleW'(1);
      scale_y_q <= forp_pkg::SampleW'(1);
    end else if (wr) begin
      unique case (paddr[3:2])
        forp_pkg::REG_MODE:    mode_q    <= pwdata[2:0];
        forp_pkg::REG_SCALE_X: scale_x_q <= pwdata[forp_pkg::SampleW-1:0];
        forp_pkg::REG_SCALE_Y: scale_y_q <= pwdata[forp_pkg::SampleW-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[3:2])
      forp_pkg::REG_MODE:    prdata = {29'd0, mode_q};
      forp_pkg::REG_SCALE_X: prdata = {8'd0, scale_x_q};
      forp_pkg::REG_SCALE_Y: prdata = {8'd0, scale_y_q};
      default:               prdata = '0;
    endcase
  end

  logic            push, full, pop, empty;
  forp_pkg::item_t f_item, q_item;

  forp_front u_front (
    .clk_i, .rst_ni,
    .mode_i(mode_q), .scale_x_i(scale_x_q), .scale_y_i(scale_y_q),
    .in_valid_i, .in_ready_o,
    .x_first_i, .x_second_i, .y_first_i, .y_second_i,
    .push_o(push), .item_o(f_item), .full_i(full)
  );

  forp_fifo u_fifo (
    .clk_i, .rst_ni,
    .push_i(push), .item_i(f_item), .full_o(full),
    .pop_i(pop), .empty_o(empty), .item_o(q_item)
  );

  forp_back u_back (
    .clk_i, .rst_ni,
    .empty_i(empty), .item_i(q_item), .pop_o(pop),
    .out_valid_o, .out_ready_i,
    .x_fw_o(x_forward_degree_o), .x_bw_o(x_backward_degree_o),
    .y_fw_o(y_forward_degree_o), .y_bw_o(y_backward_degree_o)
  );

endmodule
